@@ rtl/assert_macros.svh @@
// Assertion helpers for the decoder, clocked on aclk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset is released
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define CHK_IMPLY(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/glzw_pkg.sv @@
package glzw_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int TABLE_AW      = 12;
    localparam int TABLE_DEPTH   = 1 << TABLE_AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_DECODE,
        S_FIRSTP,
        S_FIRSTC,
        S_UNWIND,
        S_ADD
    } state_t;

    typedef enum logic [2:0] {
        PH_AWAIT_CLEAR,
        PH_FIRST,
        PH_NORMAL,
        PH_END,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        FN_PUSH,
        FN_PULL,
        FN_RESTART,
        FN_NONE
    } func_t;

    typedef enum logic [2:0] {
        ST_PIXEL,
        ST_ACCEPT,
        ST_REFUSE,
        ST_NEED,
        ST_CONTROL,
        ST_END,
        ST_ERROR
    } status_t;

    typedef enum logic [1:0] {
        PX_ZERO,
        PX_STACK,
        PX_CODE
    } pix_sel_t;

    typedef struct packed {
        logic     push_byte;
        logic     restart;
        logic     take_code;
        logic     reset_dict;
        logic     set_prev;
        logic     pop_start;
        logic     latch_fp;
        logic     chain_start;
        logic     chain_step;
        logic     chain_end;
        logic     add_entry;
        logic     emit;
        status_t  emit_status;
        pix_sel_t emit_pix;
    } cmd_t;

    typedef struct packed {
        logic stack_nonempty;
        logic buf_full;
        logic enough_bits;
        logic code_is_cc;
        logic code_is_eoi;
        logic code_gt_cc;
        logic code_le_nfc;
        logic chain_more;
    } sts_t;

endpackage

@@ rtl/gif_lzw_decoder.sv @@
// Push, restart and pulls answered without a code: the result beat follows in the next cycle.
// Pull popping a buffered pixel: S_POP registers the stack read and emits it. Pull decoding
// the first code after a clear, a control code or a bad code: S_DECODE emits the result.
// Other codes: S_DECODE, S_FIRSTP, S_FIRSTC, then S_UNWIND at one table step per cycle (the
// prefix/suffix memory read port sets this) and S_ADD; later pixels of the string pop via S_POP.
// One item in flight; the next beat is taken while a result waits if the output takes it.
// Synchronous active-low reset clears control state and stack count; dictionary/stack RAM kept.
`include "assert_macros.svh"

module gif_lzw_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] compressed_byte
    input  logic [1:0] s_tuser,   // [1:0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] pixel_index
    output logic [2:0] m_tuser,   // [2:0] status
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data   // min_code_size
);

    glzw_pkg::cmd_t cmd;
    glzw_pkg::sts_t sts;
    logic           out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid || m_tready;

    glzw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser),
        .out_free (out_free),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    glzw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    `CHK_IMPLY(a_accept_room, s_tvalid && s_tready, !m_tvalid || m_tready, "beat taken with output full")
    `CHK_IMPLY(a_pop_nonempty, cmd.pop_start, sts.stack_nonempty, "pop from empty pixel stack")
    `CHK_IMPLY(a_emit_room, cmd.emit, !m_tvalid || m_tready, "result overwrites pending beat")
    `CHK_ALWAYS(a_status_code, !m_tvalid || m_tuser != 3'd7, "undefined status code")

endmodule

@@ rtl/glzw_dp.sv @@
module glzw_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [3:0]          cfg_data,
    input  logic [7:0]          in_byte,
    input  glzw_pkg::cmd_t      cmd,
    output glzw_pkg::sts_t      sts,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [7:0]          m_tdata,
    output logic [2:0]          m_tuser
);

    localparam int AW = glzw_pkg::TABLE_AW;

    logic [11:0] prefix_mem [glzw_pkg::TABLE_DEPTH];
    logic [7:0]  suffix_mem [glzw_pkg::TABLE_DEPTH];
    logic [7:0]  first_mem  [glzw_pkg::TABLE_DEPTH];
    logic [7:0]  stack_mem  [glzw_pkg::TABLE_DEPTH];

    logic [3:0]    cfg_reg;
    logic [3:0]    width_reg, width_next;
    logic [AW:0]   nfc_reg, nfc_next;
    logic [AW-1:0] prev_reg, prev_next;
    logic [18:0]   buf_reg, buf_next;
    logic [4:0]    bcnt_reg, bcnt_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [AW-1:0] code_reg, code_next;
    logic [7:0]    fp_reg, fp_next;
    logic [7:0]    first_reg, first_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW:0]   guard_reg, guard_next;

    logic          m_valid_reg;
    logic [2:0]    m_status_reg;
    logic [7:0]    m_pix_reg;

    logic [AW-1:0] prefix_rd;
    logic [7:0]    suffix_rd, first_rd, stack_rd;

    logic [3:0]    eff_min;
    logic [8:0]    cc;
    logic [AW:0]   cc13, roots;
    logic [AW:0]   code13;
    logic [AW-1:0] mask, code_new;
    logic          case_lit;
    logic [7:0]    fc;
    logic [AW-1:0] tab_raddr, first_raddr, stack_raddr;
    logic          push_en;
    logic [7:0]    push_val;
    logic [AW:0]   nfc_inc;

    always_comb begin
        if (cfg_reg < 4'd2) begin
            eff_min = 4'd2;
        end else if (cfg_reg > 4'd8) begin
            eff_min = 4'd8;
        end else begin
            eff_min = cfg_reg;
        end
    end

    assign cc       = 9'd1 << eff_min;
    assign cc13     = {4'd0, cc};
    assign roots    = cc13 + 13'd2;
    assign code13   = {1'b0, code_reg};
    assign mask     = 12'hFFF >> (4'd12 - width_reg);
    assign code_new = buf_reg[11:0] & mask;
    assign case_lit = code13 < nfc_reg;
    assign fc       = (code13 >= roots) ? first_rd : code_reg[7:0];
    assign nfc_inc  = nfc_reg + 13'd1;

    // follow the chain straight from the prefix read while unwinding
    assign tab_raddr   = cmd.chain_step ? prefix_rd : (case_lit ? code_reg : prev_reg);
    assign first_raddr = cmd.latch_fp ? code_reg : prev_reg;
    assign stack_raddr = AW'(cnt_reg - 13'd1);

    always_comb begin
        push_en  = 1'b0;
        push_val = fp_reg;
        if (cmd.chain_start && !case_lit) begin
            push_en = 1'b1;
        end else if (cmd.chain_step) begin
            push_en  = 1'b1;
            push_val = suffix_rd;
        end else if (cmd.chain_end) begin
            push_en  = 1'b1;
            push_val = cur_reg[7:0];
        end
    end

    always_comb begin
        width_next = width_reg;
        nfc_next   = nfc_reg;
        prev_next  = prev_reg;
        buf_next   = buf_reg;
        bcnt_next  = bcnt_reg;
        cnt_next   = cnt_reg;
        code_next  = code_reg;
        fp_next    = fp_reg;
        first_next = first_reg;
        cur_next   = cur_reg;
        guard_next = guard_reg;

        if (cmd.push_byte) begin
            buf_next  = buf_reg | (19'(in_byte) << bcnt_reg);
            bcnt_next = bcnt_reg + 5'd8;
        end
        if (cmd.take_code) begin
            code_next = code_new;
            buf_next  = buf_reg >> width_reg;
            bcnt_next = bcnt_reg - {1'b0, width_reg};
        end
        if (cmd.latch_fp) begin
            fp_next = ({1'b0, prev_reg} >= roots) ? first_rd : prev_reg[7:0];
        end
        if (cmd.chain_start) begin
            first_next = case_lit ? fc : fp_reg;
            cur_next   = case_lit ? code_reg : prev_reg;
            guard_next = '0;
        end
        if (cmd.chain_step) begin
            cur_next   = prefix_rd;
            guard_next = guard_reg + 13'd1;
        end
        if (push_en && !cnt_reg[AW]) begin
            cnt_next = cnt_reg + 13'd1;
        end
        if (cmd.pop_start) begin
            cnt_next = cnt_reg - 13'd1;
        end
        if (cmd.add_entry && !nfc_reg[AW]) begin
            nfc_next = nfc_inc;
            if (nfc_inc == (13'd1 << width_reg) &&
                width_reg < 4'(glzw_pkg::MAX_CODE_BITS)) begin
                width_next = width_reg + 4'd1;
            end
        end
        if (cmd.set_prev) begin
            prev_next = code_reg;
        end
        if (cmd.reset_dict || cmd.restart) begin
            width_next = eff_min + 4'd1;
            nfc_next   = roots;
        end
        if (cmd.restart) begin
            cnt_next  = '0;
            buf_next  = '0;
            bcnt_next = '0;
            prev_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= 4'd8;
            width_reg   <= 4'd9;
            nfc_reg     <= 13'd258;
            prev_reg    <= '0;
            buf_reg     <= '0;
            bcnt_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            width_reg <= width_next;
            nfc_reg   <= nfc_next;
            prev_reg  <= prev_next;
            buf_reg   <= buf_next;
            bcnt_reg  <= bcnt_next;
            cnt_reg   <= cnt_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        code_reg  <= code_next;
        fp_reg    <= fp_next;
        first_reg <= first_next;
        cur_reg   <= cur_next;
        guard_reg <= guard_next;
        if (cmd.emit) begin
            m_status_reg <= cmd.emit_status;
            case (cmd.emit_pix)
                glzw_pkg::PX_STACK: m_pix_reg <= stack_rd;
                glzw_pkg::PX_CODE:  m_pix_reg <= code_reg[7:0];
                default:            m_pix_reg <= 8'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.add_entry && !nfc_reg[AW]) begin
            prefix_mem[nfc_reg[AW-1:0]] <= prev_reg;
            suffix_mem[nfc_reg[AW-1:0]] <= first_reg;
            first_mem[nfc_reg[AW-1:0]]  <= fp_reg;
        end
        prefix_rd <= prefix_mem[tab_raddr];
        suffix_rd <= suffix_mem[tab_raddr];
        first_rd  <= first_mem[first_raddr];
    end

    always_ff @(posedge aclk) begin
        if (push_en && !cnt_reg[AW]) begin
            stack_mem[cnt_reg[AW-1:0]] <= push_val;
        end
        stack_rd <= stack_mem[stack_raddr];
    end

    assign sts.stack_nonempty = cnt_reg != '0;
    assign sts.buf_full       = bcnt_reg > 5'd11;
    assign sts.enough_bits    = bcnt_reg >= {1'b0, width_reg};
    assign sts.code_is_cc     = code13 == cc13;
    assign sts.code_is_eoi    = code13 == cc13 + 13'd1;
    assign sts.code_gt_cc     = code13 > cc13;
    assign sts.code_le_nfc    = code13 <= nfc_reg;
    assign sts.chain_more     = ({1'b0, cur_reg} >= roots) && !guard_reg[AW];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tuser  = m_status_reg;

endmodule

@@ rtl/glzw_ctrl.sv @@
module glzw_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic [1:0]     s_func,
    input  logic           out_free,
    input  glzw_pkg::sts_t sts,
    output logic           s_tready,
    output glzw_pkg::cmd_t cmd
);

    glzw_pkg::state_t state_reg, state_next;
    glzw_pkg::phase_t phase_reg, phase_next;
    logic             accept;

    assign s_tready = (state_reg == glzw_pkg::S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            glzw_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_func == glzw_pkg::FN_RESTART) begin
                        phase_next = glzw_pkg::PH_AWAIT_CLEAR;
                    end else if (s_func == glzw_pkg::FN_PULL) begin
                        if (sts.stack_nonempty) begin
                            state_next = glzw_pkg::S_POP;
                        end else if (phase_reg != glzw_pkg::PH_END &&
                                     phase_reg != glzw_pkg::PH_ERROR &&
                                     sts.enough_bits) begin
                            state_next = glzw_pkg::S_DECODE;
                        end
                    end
                end
            end
            glzw_pkg::S_POP: state_next = glzw_pkg::S_IDLE;
            glzw_pkg::S_DECODE: begin
                state_next = glzw_pkg::S_IDLE;
                if (phase_reg == glzw_pkg::PH_AWAIT_CLEAR) begin
                    phase_next = sts.code_is_cc ? glzw_pkg::PH_FIRST : glzw_pkg::PH_ERROR;
                end else if (sts.code_is_cc) begin
                    phase_next = glzw_pkg::PH_FIRST;
                end else if (sts.code_is_eoi) begin
                    phase_next = glzw_pkg::PH_END;
                end else if (phase_reg == glzw_pkg::PH_FIRST) begin
                    phase_next = sts.code_gt_cc ? glzw_pkg::PH_ERROR : glzw_pkg::PH_NORMAL;
                end else if (sts.code_le_nfc) begin
                    state_next = glzw_pkg::S_FIRSTP;
                end else begin
                    phase_next = glzw_pkg::PH_ERROR;
                end
            end
            glzw_pkg::S_FIRSTP: state_next = glzw_pkg::S_FIRSTC;
            glzw_pkg::S_FIRSTC: state_next = glzw_pkg::S_UNWIND;
            glzw_pkg::S_UNWIND: begin
                if (!sts.chain_more) begin
                    state_next = glzw_pkg::S_ADD;
                end
            end
            glzw_pkg::S_ADD: begin
                state_next = sts.stack_nonempty ? glzw_pkg::S_POP : glzw_pkg::S_IDLE;
            end
            default: state_next = glzw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.emit_status = glzw_pkg::ST_PIXEL;
        cmd.emit_pix    = glzw_pkg::PX_ZERO;
        unique case (state_reg)
            glzw_pkg::S_IDLE: begin
                if (accept) begin
                    cmd.emit = 1'b1;
                    case (s_func)
                        glzw_pkg::FN_PUSH: begin
                            if (sts.buf_full) begin
                                cmd.emit_status = glzw_pkg::ST_REFUSE;
                            end else begin
                                cmd.push_byte   = 1'b1;
                                cmd.emit_status = glzw_pkg::ST_ACCEPT;
                            end
                        end
                        glzw_pkg::FN_RESTART: begin
                            cmd.restart     = 1'b1;
                            cmd.emit_status = glzw_pkg::ST_CONTROL;
                        end
                        glzw_pkg::FN_PULL: begin
                            if (sts.stack_nonempty) begin
                                cmd.emit      = 1'b0;
                                cmd.pop_start = 1'b1;
                            end else if (phase_reg == glzw_pkg::PH_END) begin
                                cmd.emit_status = glzw_pkg::ST_END;
                            end else if (phase_reg == glzw_pkg::PH_ERROR) begin
                                cmd.emit_status = glzw_pkg::ST_ERROR;
                            end else if (!sts.enough_bits) begin
                                cmd.emit_status = glzw_pkg::ST_NEED;
                            end else begin
                                cmd.emit      = 1'b0;
                                cmd.take_code = 1'b1;
                            end
                        end
                        default: cmd.emit_status = glzw_pkg::ST_REFUSE;
                    endcase
                end
            end
            glzw_pkg::S_POP: begin
                cmd.emit     = 1'b1;
                cmd.emit_pix = glzw_pkg::PX_STACK;
            end
            glzw_pkg::S_DECODE: begin
                cmd.emit = 1'b1;
                if (phase_reg == glzw_pkg::PH_AWAIT_CLEAR) begin
                    if (sts.code_is_cc) begin
                        cmd.reset_dict  = 1'b1;
                        cmd.emit_status = glzw_pkg::ST_CONTROL;
                    end else begin
                        cmd.emit_status = glzw_pkg::ST_ERROR;
                    end
                end else if (sts.code_is_cc) begin
                    cmd.reset_dict  = 1'b1;
                    cmd.emit_status = glzw_pkg::ST_CONTROL;
                end else if (sts.code_is_eoi) begin
                    cmd.emit_status = glzw_pkg::ST_END;
                end else if (phase_reg == glzw_pkg::PH_FIRST) begin
                    if (sts.code_gt_cc) begin
                        cmd.emit_status = glzw_pkg::ST_ERROR;
                    end else begin
                        cmd.set_prev = 1'b1;
                        cmd.emit_pix = glzw_pkg::PX_CODE;
                    end
                end else if (sts.code_le_nfc) begin
                    cmd.emit = 1'b0;
                end else begin
                    cmd.emit_status = glzw_pkg::ST_ERROR;
                end
            end
            glzw_pkg::S_FIRSTP: cmd.latch_fp = 1'b1;
            glzw_pkg::S_FIRSTC: cmd.chain_start = 1'b1;
            glzw_pkg::S_UNWIND: begin
                if (sts.chain_more) begin
                    cmd.chain_step = 1'b1;
                end else begin
                    cmd.chain_end = 1'b1;
                end
            end
            glzw_pkg::S_ADD: begin
                cmd.add_entry = 1'b1;
                cmd.set_prev  = 1'b1;
                if (sts.stack_nonempty) begin
                    cmd.pop_start = 1'b1;
                end else begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = glzw_pkg::ST_NEED;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= glzw_pkg::S_IDLE;
            phase_reg <= glzw_pkg::PH_AWAIT_CLEAR;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule
